FILE: sv/toe_pkg.sv
// shared constants, types and helpers of the tape op executor
package toe_pkg;
  localparam int TAPE_CELLS = 32768;
  localparam int CELL_BITS = 8;
  localparam int ADDR_W = $clog2(TAPE_CELLS);
  localparam int LEN_W = ADDR_W + 1;
  localparam int PW = ((ADDR_W > 16) ? ADDR_W : 16) + 2;
  localparam int WALK_LIMIT = 2 * TAPE_CELLS + 65536;
  localparam int WALK_W = $clog2(WALK_LIMIT + 2);

  typedef logic [CELL_BITS-1:0] cell_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [PW-1:0] pos_t;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_MACC = 4'd1;
  localparam logic [3:0] OP_MAC = 4'd2;
  localparam logic [3:0] OP_SET = 4'd3;
  localparam logic [3:0] OP_MMUL = 4'd4;
  localparam logic [3:0] OP_MOVE = 4'd5;
  localparam logic [3:0] OP_SCAN = 4'd6;
  localparam logic [3:0] OP_PUT = 4'd7;
  localparam logic [3:0] OP_GET = 4'd8;
  localparam logic [3:0] OP_FWD = 4'd9;
  localparam logic [3:0] OP_REW = 4'd10;
  localparam logic [3:0] OP_MZSCAN = 4'd11;
  localparam logic [3:0] OP_VALSCAN = 4'd12;
  localparam logic [3:0] OP_END = 4'd13;

  function automatic cell_t cx(input logic signed [15:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    return w[CELL_BITS-1:0];
  endfunction

  function automatic pos_t padd(input addr_t p, input logic signed [15:0] o);
    pos_t a;
    pos_t b;
    a = signed'(PW'(p));
    b = PW'(o);
    return a + b;
  endfunction
endpackage

FILE: sv/tape_op_executor.sv
// tape op executor: sequencer around a single-port tape memory
// move/set/get/end and ignored ops finish when taken; add and jumps read the cell, then write it;
// put only reads it; mul-add and mul-mul read the source, then write the target; mul-add-clear then
// zeroes the source; stride scan reads nonzero cells, loop scans repeat their body; one item
// at a time, next taken once result is free; throughput is set by the single tape port: one read
// or one write per cycle; reset: synchronous active low; clearing pass zeroes tape, no beat taken
module tape_op_executor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_req_type,
  input  logic [15:0] in_op_value,
  input  logic [15:0] in_op_buf,
  input  logic [15:0] in_op_move,
  input  logic [15:0] in_body_value,
  input  logic [15:0] in_body_target,
  input  logic [15:0] in_body_move,
  input  logic [15:0] in_partner_add,
  input  logic [15:0] in_partner_move,
  input  logic [7:0]  in_input_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_put_valid,
  output logic [7:0]  out_put_byte,
  output logic        out_branch_taken,
  output logic        out_fault,
  output logic        out_halted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import toe_pkg::*;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDP = 4'd2;
  localparam logic [3:0] S_RDT = 4'd3;
  localparam logic [3:0] S_WZ = 4'd4;
  localparam logic [3:0] S_LRD = 4'd5;
  localparam logic [3:0] S_BRD = 4'd6;
  localparam logic [3:0] S_BODY = 4'd7;
  localparam logic [3:0] S_LTG = 4'd8;
  localparam logic [3:0] S_LZ = 4'd9;
  localparam logic [3:0] S_LIS = 4'd10;

  cell_t tape_mem [TAPE_CELLS];
  cell_t mem_q;
  logic  mem_we, mem_re;
  addr_t mem_addr;
  cell_t mem_wd;

  logic [3:0] state_r, state_nxt;
  addr_t clr_r, clr_nxt;
  addr_t pos_r, pos_nxt;
  addr_t wp_r, wp_nxt;
  addr_t tgt_r, tgt_nxt;
  logic halted_r, halted_nxt, fault_r, fault_nxt;
  logic [15:0] len_r;
  logic out_valid_r, out_valid_nxt;
  logic sub_r, sub_nxt;
  logic [WALK_W-1:0] n_r, n_nxt, n_inc;
  logic [3:0] typ_r, typ_nxt;
  logic signed [15:0] val_r, buf_r, mv_r, bv_r, bt_r, bm_r, pa_r, pm_r;
  cell_t m_r, m_nxt;
  logic put_r, put_nxt, taken_r, taken_nxt;
  logic [7:0] pbyte_r, pbyte_nxt;

  logic [LEN_W-1:0] len_eff;
  logic acc, fin, fin_fault, fin_keep, halt_op, fault_n;
  pos_t fin_pos, np;
  logic tk;

  function automatic logic ins(input pos_t a, input logic [LEN_W-1:0] l);
    return (a >= 0) && (a < signed'(PW'(l)));
  endfunction

  assign len_eff = (32'(len_r) >= 32'(TAPE_CELLS)) ? LEN_W'(TAPE_CELLS) : LEN_W'(len_r);
  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign n_inc = n_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    pos_nxt = pos_r;
    wp_nxt = wp_r;
    tgt_nxt = tgt_r;
    sub_nxt = sub_r;
    n_nxt = n_r;
    typ_nxt = typ_r;
    m_nxt = m_r;
    halted_nxt = halted_r;
    fault_nxt = fault_r;
    put_nxt = put_r;
    taken_nxt = taken_r;
    pbyte_nxt = pbyte_r;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_addr = wp_r;
    mem_wd = '0;
    fin = 1'b0;
    fin_fault = 1'b0;
    fin_keep = 1'b0;
    halt_op = 1'b0;
    fin_pos = padd(wp_r, mv_r);
    np = padd(wp_r, mv_r);
    tk = 1'b0;
    fault_n = fault_r;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(TAPE_CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          typ_nxt = in_req_type;
          wp_nxt = pos_r;
          n_nxt = '0;
          sub_nxt = 1'b0;
          mem_addr = pos_r;
          fin_pos = padd(pos_r, in_op_move);
          if (halted_r) begin
            fin = 1'b1;
            fin_keep = 1'b1;
          end else if (!ins(signed'(PW'(pos_r)), len_eff)) begin
            fin = 1'b1;
            fin_fault = 1'b1;
          end else begin
            case (in_req_type)
              OP_SET: begin
                mem_we = 1'b1;
                mem_wd = cx(in_op_value);
                fin = 1'b1;
              end
              OP_GET: begin
                mem_we = 1'b1;
                mem_wd = cell_t'(in_input_byte);
                fin = 1'b1;
              end
              OP_END: begin
                fin = 1'b1;
                fin_keep = 1'b1;
                halt_op = 1'b1;
              end
              OP_ADD, OP_MACC, OP_MAC, OP_MMUL, OP_SCAN, OP_PUT, OP_FWD, OP_REW: begin
                mem_re = 1'b1;
                state_nxt = S_RDP;
              end
              OP_MZSCAN, OP_VALSCAN: begin
                mem_re = 1'b1;
                state_nxt = S_LRD;
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end
      S_RDP: begin
        case (typ_r)
          OP_ADD: begin
            mem_we = 1'b1;
            mem_wd = mem_q + cx(val_r);
            fin = 1'b1;
          end
          OP_MACC, OP_MAC, OP_MMUL: begin
            m_nxt = cx(val_r) * mem_q;
            np = padd(wp_r, buf_r);
            if (!ins(np, len_eff)) begin
              fin = 1'b1;
              fin_fault = 1'b1;
            end else begin
              tgt_nxt = np[ADDR_W-1:0];
              mem_addr = np[ADDR_W-1:0];
              mem_re = 1'b1;
              state_nxt = S_RDT;
            end
          end
          OP_SCAN: begin
            np = padd(wp_r, val_r);
            if (mem_q == '0) begin
              fin = 1'b1;
            end else begin
              n_nxt = n_inc;
              if (val_r == 16'sd0 || 32'(n_inc) > 32'(WALK_LIMIT) || !ins(np, len_eff)) begin
                fin = 1'b1;
                fin_fault = 1'b1;
              end else begin
                wp_nxt = np[ADDR_W-1:0];
                mem_addr = np[ADDR_W-1:0];
                mem_re = 1'b1;
              end
            end
          end
          OP_PUT: begin
            fin = 1'b1;
            put_nxt = 1'b1;
            pbyte_nxt = mem_q[7:0];
          end
          OP_FWD, OP_REW: begin
            tk = (typ_r == OP_FWD) ? (mem_q == '0) : (mem_q != '0);
            mem_we = 1'b1;
            mem_wd = mem_q + cx(tk ? pa_r : buf_r);
            fin = 1'b1;
            taken_nxt = tk;
            fin_pos = padd(wp_r, tk ? pm_r : mv_r);
          end
          default: fin = 1'b1;
        endcase
      end
      S_RDT: begin
        mem_we = 1'b1;
        mem_addr = tgt_r;
        mem_wd = (typ_r == OP_MMUL) ? cell_t'(mem_q * m_r) : cell_t'(mem_q + m_r);
        if (typ_r == OP_MACC) state_nxt = S_WZ;
        else fin = 1'b1;
      end
      S_WZ: begin
        mem_we = 1'b1;
        fin = 1'b1;
      end
      S_LRD: begin
        if (sub_r) n_nxt = n_inc;
        if (mem_q == '0) begin
          mem_we = 1'b1;
          mem_wd = mem_q + cx(pa_r);
          fin = 1'b1;
          fin_pos = padd(wp_r, pm_r);
        end else if (sub_r && 32'(n_inc) >= 32'(WALK_LIMIT)) begin
          fin = 1'b1;
          fin_fault = 1'b1;
        end else begin
          mem_we = 1'b1;
          mem_wd = mem_q + cx(buf_r);
          if (!ins(np, len_eff)) begin
            fin = 1'b1;
            fin_fault = 1'b1;
          end else begin
            wp_nxt = np[ADDR_W-1:0];
            state_nxt = S_BRD;
          end
        end
      end
      S_BRD: begin
        mem_re = 1'b1;
        state_nxt = S_BODY;
      end
      S_BODY: begin
        if (typ_r == OP_VALSCAN) begin
          mem_we = 1'b1;
          mem_wd = mem_q + cx(bv_r);
          np = padd(wp_r, bm_r);
          sub_nxt = 1'b1;
          if (!ins(np, len_eff)) begin
            fin = 1'b1;
            fin_fault = 1'b1;
          end else begin
            wp_nxt = np[ADDR_W-1:0];
            state_nxt = S_LIS;
          end
        end else begin
          m_nxt = cx(bv_r) * mem_q;
          np = padd(wp_r, bt_r);
          if (!ins(np, len_eff)) begin
            fin = 1'b1;
            fin_fault = 1'b1;
          end else begin
            tgt_nxt = np[ADDR_W-1:0];
            mem_addr = np[ADDR_W-1:0];
            mem_re = 1'b1;
            state_nxt = S_LTG;
          end
        end
      end
      S_LTG: begin
        mem_we = 1'b1;
        mem_addr = tgt_r;
        mem_wd = mem_q + m_r;
        state_nxt = S_LZ;
      end
      S_LZ: begin
        mem_we = 1'b1;
        np = padd(wp_r, bm_r);
        sub_nxt = 1'b1;
        if (!ins(np, len_eff)) begin
          fin = 1'b1;
          fin_fault = 1'b1;
        end else begin
          wp_nxt = np[ADDR_W-1:0];
          state_nxt = S_LIS;
        end
      end
      S_LIS: begin
        mem_re = 1'b1;
        state_nxt = S_LRD;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (acc) begin
      put_nxt = 1'b0;
      taken_nxt = 1'b0;
      pbyte_nxt = '0;
    end
    if (fin) begin
      state_nxt = S_IDLE;
      fault_n = fault_r | fin_fault;
      if (!fault_n && !fin_keep) begin
        if (ins(fin_pos, len_eff)) pos_nxt = fin_pos[ADDR_W-1:0];
        else fault_n = 1'b1;
      end
      fault_nxt = fault_n;
      halted_nxt = halted_r | fault_n | halt_op;
    end
    out_valid_nxt = fin | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (mem_we) tape_mem[mem_addr] <= mem_wd;
    if (mem_re) mem_q <= tape_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      pos_r <= '0;
      halted_r <= 1'b0;
      fault_r <= 1'b0;
      len_r <= 16'd32768;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      pos_r <= pos_nxt;
      halted_r <= halted_nxt;
      fault_r <= fault_nxt;
      if (cfg_valid && cfg_ready) len_r <= cfg_data;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wp_r <= wp_nxt;
    tgt_r <= tgt_nxt;
    sub_r <= sub_nxt;
    n_r <= n_nxt;
    typ_r <= typ_nxt;
    m_r <= m_nxt;
    put_r <= put_nxt;
    taken_r <= taken_nxt;
    pbyte_r <= pbyte_nxt;
    if (acc) begin
      val_r <= in_op_value;
      buf_r <= in_op_buf;
      mv_r <= in_op_move;
      bv_r <= in_body_value;
      bt_r <= in_body_target;
      bm_r <= in_body_move;
      pa_r <= in_partner_add;
      pm_r <= in_partner_move;
    end
  end

  assign out_valid = out_valid_r;
  assign out_put_valid = put_r;
  assign out_put_byte = pbyte_r;
  assign out_branch_taken = taken_r;
  assign out_fault = fault_r;
  assign out_halted = halted_r;

  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> in_stall) else $error("beat taken during tape clear");
  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_halted) else $error("fault without halt");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halt flag dropped");
  a_put_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_put_valid |-> !out_branch_taken) else $error("put and branch together");
endmodule
